// ===== hw/rtl/gbps_pkg.sv =====
// Shared types, constants and helpers of the gapped byte pattern search.
// Used by gbps_cell, gbps_outq and the top level gapped_byte_pattern_search.
package gbps_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int POSITION_BITS = 24;
    localparam int IDX_BITS      = $clog2(PATTERN_BYTES);
    localparam int LEN_BITS      = 5;
    localparam int OFFSET_BITS   = 16;
    localparam int TARGET_BITS   = POSITION_BITS + 1;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_POSITION = 3'd0,
        CFG_PATTERN_LOW    = 3'd1,
        CFG_PATTERN_HIGH   = 3'd2,
        CFG_CARE_MASK      = 3'd3,
        CFG_PATTERN_LENGTH = 3'd4,
        CFG_TARGET_OFFSET  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [PATTERN_BYTES-1:0][7:0] bytes;
        logic [PATTERN_BYTES-1:0]      care;
        logic [LEN_BITS-1:0]           eff_len;
    } t_pattern;

    typedef struct packed {
        logic                     found;
        logic [POSITION_BITS-1:0] match_position;
        logic [TARGET_BITS-1:0]   target_position;
        logic                     length_overflow;
    } t_result;

    // Length up to and including the highest cared byte, at least one.
    function automatic logic [LEN_BITS-1:0] eff_length(
        input logic [LEN_BITS-1:0]      len_cfg,
        input logic [PATTERN_BYTES-1:0] care
    );
        logic [LEN_BITS-1:0] len;
        logic [LEN_BITS-1:0] eff;
        len = len_cfg;
        eff = LEN_BITS'(1);
        if (len == '0) begin
            len = LEN_BITS'(1);
        end
        if (len > LEN_BITS'(PATTERN_BYTES)) begin
            len = LEN_BITS'(PATTERN_BYTES);
        end
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            if ((LEN_BITS'(i) < len) && care[i]) begin
                eff = LEN_BITS'(i + 1);
            end
        end
        return eff;
    endfunction

endpackage

// ===== hw/rtl/gbps_cell.sv =====
// One window cell: holds one buffer byte, hands it on each accepted request,
// and checks the incoming byte against its pattern byte. Depends on gbps_pkg.
module gbps_cell (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic [gbps_pkg::IDX_BITS-1:0] i_index,
    input  logic [7:0]                    i_byte,
    input  gbps_pkg::t_pattern            i_pattern,
    output logic [7:0]                    o_byte,
    output logic                          o_miss
);
    import gbps_pkg::*;

    logic [7:0]          r_byte;
    logic [LEN_BITS-1:0] k;
    logic                active;

    // Slot j of the window lines up with pattern byte L-1-j.
    assign active = LEN_BITS'(i_index) < i_pattern.eff_len;
    assign k      = i_pattern.eff_len - LEN_BITS'(1) - LEN_BITS'(i_index);
    assign o_miss = active && i_pattern.care[k[IDX_BITS-1:0]]
                    && (i_byte != i_pattern.bytes[k[IDX_BITS-1:0]]);
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== hw/rtl/gbps_outq.sv =====
// Two-entry result queue between the search and the result channel.
// Depends on gbps_pkg for the result record.
module gbps_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gbps_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output gbps_pkg::t_result o_result
);
    import gbps_pkg::*;

    t_result    r_slot [2];
    t_result    n_slot [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;

    assign o_valid  = r_cnt != 2'd0;
    assign o_full   = r_cnt == 2'd2;
    assign o_result = r_slot[0];
    assign pop      = o_valid && i_ready;

    always_comb begin
        n_slot[0] = r_slot[0];
        n_slot[1] = r_slot[1];
        n_cnt     = r_cnt;
        if (pop) begin
            n_slot[0] = r_slot[1];
            n_cnt     = r_cnt - 2'd1;
        end
        if (i_push) begin
            n_slot[n_cnt[0]] = i_result;
            n_cnt            = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_slot[0] <= n_slot[0];
        r_slot[1] <= n_slot[1];
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_ready) |-> !i_push)
        else $error("push into full result queue");
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result)))
        else $error("stalled result changed");
`endif

endmodule

// ===== hw/rtl/gapped_byte_pattern_search.sv =====
// Gapped byte pattern search: a row of 16 window cells compares each new byte.
// Each result is registered in the two-entry result queue before it is offered.
// Throughput: one byte per cycle; input stalls only when both result slots
// hold results that are not yet taken. Reset (synchronous): config returns to
// its defaults and the buffer position, match and overflow state clear.
// Depends on gbps_pkg, gbps_cell and gbps_outq.
module gapped_byte_pattern_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [gbps_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [gbps_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_last_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_found,
    output logic [gbps_pkg::POSITION_BITS-1:0] o_match_position,
    output logic [gbps_pkg::TARGET_BITS-1:0]   o_target_position,
    output logic                               o_length_overflow
);
    import gbps_pkg::*;

    logic [POSITION_BITS-1:0] r_start;
    logic [63:0]              r_pat_lo;
    logic [63:0]              r_pat_hi;
    logic [PATTERN_BYTES-1:0] r_care;
    logic [LEN_BITS-1:0]      r_len;
    logic [OFFSET_BITS-1:0]   r_offset;

    logic [POSITION_BITS-1:0] r_count;
    logic                     r_matched;
    logic                     r_sat;

    t_pattern                 pattern;
    logic [7:0]               cell_in  [PATTERN_BYTES];
    logic [7:0]               cell_out [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] miss;

    logic                     accept;
    logic                     q_full;
    logic [TARGET_BITS-1:0]   idx_p1;
    logic [TARGET_BITS-1:0]   pos_wide;
    logic [POSITION_BITS-1:0] pos;
    logic                     found_now;
    logic                     matched_after;
    logic                     sat_after;
    logic                     notfound_now;
    t_result                  res;
    t_result                  q_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= PATTERN_BYTES'(1);
            r_len    <= LEN_BITS'(1);
            r_offset <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_START_POSITION: r_start  <= i_cfg_data[POSITION_BITS-1:0];
                CFG_PATTERN_LOW:    r_pat_lo <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pat_hi <= i_cfg_data;
                CFG_CARE_MASK:      r_care   <= i_cfg_data[PATTERN_BYTES-1:0];
                CFG_PATTERN_LENGTH: r_len    <= i_cfg_data[LEN_BITS-1:0];
                CFG_TARGET_OFFSET:  r_offset <= i_cfg_data[OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign pattern.bytes   = {r_pat_hi, r_pat_lo};
    assign pattern.care    = r_care;
    assign pattern.eff_len = eff_length(r_len, r_care);

    assign accept = i_in_valid && o_in_ready;

    for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign cell_in[j] = i_data_byte;
        end else begin : g_body
            assign cell_in[j] = cell_out[j-1];
        end
        gbps_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (accept),
            .i_index   (IDX_BITS'(j)),
            .i_byte    (cell_in[j]),
            .i_pattern (pattern),
            .o_byte    (cell_out[j]),
            .o_miss    (miss[j])
        );
    end

    assign idx_p1   = {1'b0, r_count} + TARGET_BITS'(1);
    assign pos_wide = idx_p1 - TARGET_BITS'(pattern.eff_len);
    assign pos      = pos_wide[POSITION_BITS-1:0];

    assign found_now = accept && !r_sat && !r_matched
                       && (idx_p1 >= TARGET_BITS'(pattern.eff_len))
                       && (pos >= r_start) && (miss == '0);
    assign matched_after = r_matched || found_now;
    assign sat_after     = r_sat || (r_count == POS_MAX);
    assign notfound_now  = accept && i_last_byte && !matched_after;

    always_comb begin
        res = '0;
        if (found_now) begin
            res.found           = 1'b1;
            res.match_position  = pos;
            res.target_position = {1'b0, pos} + TARGET_BITS'(r_offset);
        end else begin
            res.length_overflow = sat_after;
        end
    end

    // buffer position state; the last byte starts a fresh buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_matched <= 1'b0;
            r_sat     <= 1'b0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_count   <= '0;
                r_matched <= 1'b0;
                r_sat     <= 1'b0;
            end else begin
                r_matched <= matched_after;
                r_sat     <= sat_after;
                if (!sat_after) begin
                    r_count <= r_count + POSITION_BITS'(1);
                end
            end
        end
    end

    gbps_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (found_now || notfound_now),
        .i_result (res),
        .o_full   (q_full),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (q_head)
    );

    assign o_in_ready        = !q_full;
    assign o_found           = q_head.found;
    assign o_match_position  = q_head.match_position;
    assign o_target_position = q_head.target_position;
    assign o_length_overflow = q_head.length_overflow;

`ifndef SYNTH
    a_found_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> !o_length_overflow)
        else $error("found result carries overflow");
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_position == '0 && o_target_position == '0))
        else $error("not-found result carries a position");
    a_sat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sat && !(accept && i_last_byte)) |=> (r_sat && $stable(r_count)))
        else $error("saturated position counter moved");
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matched |-> !found_now)
        else $error("second match reported in one buffer");
`endif

endmodule

// ===== tb/tb_gapped_byte_pattern_search.sv =====
// Self-checking testbench for gapped_byte_pattern_search: directed buffers,
// then random buffers under random register settings and handshake stalls.
// Depends on gbps_pkg and the gapped_byte_pattern_search RTL.
`timescale 1ns / 100ps

module tb_gapped_byte_pattern_search;
    import gbps_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int RANDOM_PHASES  = 12;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PRESSURE_PHASE = 7;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int END_CYCLES     = 8;

    typedef struct {
        logic [POSITION_BITS-1:0] start_pos;
        logic [63:0]              pattern_lo;
        logic [63:0]              pattern_hi;
        logic [PATTERN_BYTES-1:0] care;
        logic [LEN_BITS-1:0]      len;
        logic [OFFSET_BITS-1:0]   offset;
    } t_search_cfg;

    // Predicts the search result of each buffer and checks the reports.
    class search_scoreboard;
        logic [POSITION_BITS-1:0] start_pos;
        logic [63:0]              pattern_lo;
        logic [63:0]              pattern_hi;
        logic [PATTERN_BYTES-1:0] care;
        logic [LEN_BITS-1:0]      len_cfg;
        logic [OFFSET_BITS-1:0]   offset;
        logic [7:0]               window [PATTERN_BYTES];   // [0] is the newest byte
        logic [POSITION_BITS-1:0] byte_count;
        bit                       matched;
        bit                       saturated;
        t_result                  reports_due [$];
        int                       errors;

        function new();
            start_pos  = '0;
            pattern_lo = '0;
            pattern_hi = '0;
            care       = PATTERN_BYTES'(1);
            len_cfg    = LEN_BITS'(1);
            offset     = '0;
            errors     = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            foreach (window[i]) window[i] = 8'h00;
            byte_count = '0;
            matched    = 1'b0;
            saturated  = 1'b0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [63:0] value);
            case (idx)
                CFG_START_POSITION: start_pos  = value[POSITION_BITS-1:0];
                CFG_PATTERN_LOW:    pattern_lo = value;
                CFG_PATTERN_HIGH:   pattern_hi = value;
                CFG_CARE_MASK:      care       = value[PATTERN_BYTES-1:0];
                CFG_PATTERN_LENGTH: len_cfg    = value[LEN_BITS-1:0];
                CFG_TARGET_OFFSET:  offset     = value[OFFSET_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] pattern_byte(int i);
            logic [127:0] pat;
            pat = {pattern_hi, pattern_lo};
            return pat[8*i +: 8];
        endfunction

        // Trim trailing gap bytes; zero length counts as one, long saturates.
        function int unsigned match_length();
            int unsigned lim;
            int unsigned eff;
            lim = len_cfg;
            eff = 1;
            if (lim == 0) lim = 1;
            if (lim > PATTERN_BYTES) lim = PATTERN_BYTES;
            for (int i = 0; i < lim; i++) begin
                if (care[i]) eff = i + 1;
            end
            return eff;
        endfunction

        function void take_byte(logic [7:0] b, logic lst);
            int unsigned idx;
            int unsigned mlen;
            int unsigned pos;
            bit          hit;
            t_result     rep;
            for (int i = PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            if (!saturated) begin
                idx  = byte_count;
                mlen = match_length();
                if (!matched && idx + 1 >= mlen) begin
                    pos = idx + 1 - mlen;
                    if (pos >= start_pos) begin
                        hit = 1'b1;
                        for (int i = 0; i < mlen; i++) begin
                            if (care[i] && window[mlen-1-i] != pattern_byte(i)) hit = 1'b0;
                        end
                        if (hit) begin
                            matched                 = 1'b1;
                            rep.found               = 1'b1;
                            rep.match_position      = pos[POSITION_BITS-1:0];
                            rep.target_position     = TARGET_BITS'(pos + offset);
                            rep.length_overflow     = 1'b0;
                            reports_due.push_back(rep);
                        end
                    end
                end
                if (byte_count == POS_MAX) saturated = 1'b1;
                else byte_count = byte_count + 1'b1;
            end
            if (lst) begin
                if (!matched) begin
                    rep.found           = 1'b0;
                    rep.match_position  = '0;
                    rep.target_position = '0;
                    rep.length_overflow = saturated;
                    reports_due.push_back(rep);
                end
                clear_buffer();
            end
        endfunction

        function void check_report(t_result got);
            t_result want;
            if (reports_due.size() == 0) begin
                $error("unexpected result: found=%0d match_position=%0d",
                       got.found, got.match_position);
                errors++;
                return;
            end
            want = reports_due.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                errors++;
            end
            if (got.match_position !== want.match_position) begin
                $error("match_position: expected %0d, actual %0d",
                       want.match_position, got.match_position);
                errors++;
            end
            if (got.target_position !== want.target_position) begin
                $error("target_position: expected %0d, actual %0d",
                       want.target_position, got.target_position);
                errors++;
            end
            if (got.length_overflow !== want.length_overflow) begin
                $error("length_overflow: expected %0d, actual %0d",
                       want.length_overflow, got.length_overflow);
                errors++;
            end
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    logic [7:0]               i_data_byte = 8'h00;
    logic                     i_last_byte = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_found;
    logic [POSITION_BITS-1:0] o_match_position;
    logic [TARGET_BITS-1:0]   o_target_position;
    logic                     o_length_overflow;

    search_scoreboard sb;
    int               cycle_count  = 0;
    int               bytes_sent   = 0;
    bit               quiet_mode   = 1'b0;
    bit               hold_request = 1'b0;

    gapped_byte_pattern_search dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_found           (o_found),
        .o_match_position  (o_match_position),
        .o_target_position (o_target_position),
        .o_length_overflow (o_length_overflow)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_report('{o_found, o_match_position, o_target_position,
                              o_length_overflow});
        end
    end

    // Offer one request, hold it until accepted.
    task automatic push_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic drive_reg(input t_cfg_idx idx, input logic [63:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_cfg(input t_search_cfg c);
        drive_reg(CFG_START_POSITION, 64'(c.start_pos));
        drive_reg(CFG_PATTERN_LOW, c.pattern_lo);
        drive_reg(CFG_PATTERN_HIGH, c.pattern_hi);
        drive_reg(CFG_CARE_MASK, 64'(c.care));
        drive_reg(CFG_PATTERN_LENGTH, 64'(c.len));
        drive_reg(CFG_TARGET_OFFSET, 64'(c.offset));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Drop valid and wait for every report, then let the pipeline drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] narrow_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h5A;
            default: return 8'hA5;
        endcase
    endfunction

    function automatic logic [7:0] filler_byte();
        int r;
        r = $urandom_range(0, 3);
        if (r < 2) return sb.pattern_byte($urandom_range(0, PATTERN_BYTES - 1));
        if (r == 2) return 8'($urandom);
        return narrow_byte();
    endfunction

    function automatic t_search_cfg random_cfg(int ph);
        t_search_cfg  c;
        logic [127:0] pat;
        bit           narrow;
        narrow = $urandom_range(0, 1);
        for (int k = 0; k < PATTERN_BYTES; k++) begin
            pat[8*k +: 8] = narrow ? narrow_byte() : 8'($urandom);
        end
        c.start_pos  = POSITION_BITS'($urandom_range(0, 12));
        c.pattern_lo = pat[63:0];
        c.pattern_hi = pat[127:64];
        c.care       = PATTERN_BYTES'($urandom);
        c.len        = ($urandom_range(0, 4) == 0) ? LEN_BITS'($urandom_range(0, 31))
                                                   : LEN_BITS'($urandom_range(1, 16));
        c.offset     = OFFSET_BITS'($urandom);
        case (ph % 6)
            0: begin
                c.care   = '1;
                c.len    = LEN_BITS'(PATTERN_BYTES);
                c.offset = '1;
            end
            1: begin
                c.care      = '0;
                c.start_pos = POSITION_BITS'($urandom_range(0, 30));
            end
            2: c.start_pos = '1;
            3: c.len = $urandom_range(0, 1) ? LEN_BITS'(0) : LEN_BITS'($urandom_range(17, 31));
            4: begin
                c.start_pos = '0;
                c.offset    = '0;
                c.care      = c.care | PATTERN_BYTES'(1);
            end
            default: ;
        endcase
        if (ph == PRESSURE_PHASE) begin
            c.care      = '0;
            c.start_pos = '0;
        end
        return c;
    endfunction

    // One buffer of filler, usually with a copy of the pattern planted in it.
    task automatic send_buffer(input bit short_only);
        logic [7:0]  bytes_q [$];
        int          body_len;
        int          at;
        int unsigned mlen;
        bit          plant;
        if (short_only) begin
            body_len = $urandom_range(1, 3);
            plant    = 1'b0;
        end else begin
            body_len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 20)
                                                  : $urandom_range(21, 60);
            plant    = ($urandom_range(0, 3) != 0);
        end
        for (int i = 0; i < body_len; i++) bytes_q.push_back(filler_byte());
        if (plant) begin
            mlen = sb.match_length();
            at   = $urandom_range(0, bytes_q.size());
            for (int i = 0; i < mlen; i++) begin
                bytes_q.insert(at + i, sb.care[i] ? sb.pattern_byte(i) : 8'($urandom));
            end
        end
        if (bytes_q.size() == 0) bytes_q.push_back(filler_byte());
        foreach (bytes_q[i]) push_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    initial begin
        t_search_cfg c;
        int          phase_end;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: single cared byte 0x00 at any position.
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        settle();

        // No cared byte and zero length: first byte at the start position hits.
        c = '{start_pos: POSITION_BITS'(2), pattern_lo: '0, pattern_hi: '0, care: '0,
              len: '0, offset: '1};
        apply_cfg(c);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b0);
        push_byte(8'h78, 1'b1);
        settle();

        // Oversized length saturates; only the end bytes are cared.
        c = '{start_pos: '0, pattern_lo: 64'hA5A5_A5A5_A5A5_A5FF,
              pattern_hi: 64'h0011_2233_4455_6677, care: 16'h8001,
              len: LEN_BITS'(31), offset: OFFSET_BITS'(1)};
        apply_cfg(c);
        push_byte(8'hFF, 1'b0);
        repeat (14) push_byte(8'($urandom), 1'b0);
        push_byte(8'h00, 1'b1);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            c = random_cfg(ph);
            apply_cfg(c);
            quiet_mode = (ph % 4 == 3) || (ph == PRESSURE_PHASE);
            if (ph == PRESSURE_PHASE) hold_request = 1'b1;
            phase_end = bytes_sent + ITEMS_PER_PHASE;
            while (bytes_sent < phase_end) send_buffer(ph == PRESSURE_PHASE);
            settle();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
